// ===== sv/bcbs_pkg.sv =====
`default_nettype none

package bcbs_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned COUNT_W = 9;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_FILL   = 3'd1,
		CMD_ADD    = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_OR     = 3'd4,
		CMD_ANDNOT = 3'd5,
		CMD_FIND   = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SEEK_SET,
		ST_SEEK_CLEAR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		UM_UPDATE,
		UM_SEEK_SET,
		UM_SEEK_CLEAR
	} unit_mode_t;

	typedef struct packed {
		unit_mode_t  mode;
		cmd_t        cmd;
		logic [1:0]  word_sel;
		logic [7:0]  first;
		logic [7:0]  range_lo;
		logic [7:0]  range_hi;
		logic [1:0]  word_index;
		logic [63:0] word_value;
		logic [7:0]  lower;
	} unit_ctl_t;

	typedef struct packed {
		logic [63:0] new_word;
		logic [6:0]  pop;
		logic        hit;
		logic [5:0]  hit_idx;
	} unit_res_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, pop8(v[8*i +: 8])};
		end
		return n;
	endfunction

	// Returns {hit, index of the lowest set bit}.
	function automatic logic [6:0] lsb64(input logic [63:0] v);
		logic [7:0] byte_nz;
		logic [2:0] byte_i;
		logic [2:0] bit_i;
		logic [7:0] sel;
		logic       hit;
		byte_i = 3'd0;
		bit_i = 3'd0;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			byte_nz[i] = |v[8*i +: 8];
		end
		for (int i = 7; i >= 0; i--) begin
			if (byte_nz[i]) begin
				byte_i = i[2:0];
				hit = 1'b1;
			end
		end
		sel = v[{byte_i, 3'b000} +: 8];
		for (int i = 7; i >= 0; i--) begin
			if (sel[i]) begin
				bit_i = i[2:0];
			end
		end
		return {hit, byte_i, bit_i};
	endfunction

endpackage

`default_nettype wire

// ===== sv/bcbs_word_unit.sv =====
`default_nettype none

// Shared word unit: applies one command to one 64-bit word of the set, counts
// the members of the result, and finds the lowest bit for the run search.
module bcbs_word_unit (
	input  wire logic [63:0]       word,
	input  wire bcbs_pkg::unit_ctl_t ctl,
	output bcbs_pkg::unit_res_t    res
);

	logic [63:0] ones;
	logic [63:0] lo_mask;
	logic [63:0] hi_mask;
	logic [63:0] range_mask;
	logic [63:0] seek_mask;
	logic [63:0] seek_word;
	logic [63:0] new_word;
	logic [6:0]  lsb;
	logic        sel_hit;

	assign ones = {64{1'b1}};
	assign sel_hit = (ctl.word_sel == ctl.word_index);

	always_comb begin
		if (ctl.word_sel < ctl.range_lo[7:6]) begin
			lo_mask = '0;
		end else if (ctl.word_sel == ctl.range_lo[7:6]) begin
			lo_mask = ones << ctl.range_lo[5:0];
		end else begin
			lo_mask = ones;
		end
		if (ctl.word_sel > ctl.range_hi[7:6]) begin
			hi_mask = '0;
		end else if (ctl.word_sel == ctl.range_hi[7:6]) begin
			hi_mask = ones >> (6'd63 - ctl.range_hi[5:0]);
		end else begin
			hi_mask = ones;
		end
		range_mask = lo_mask & hi_mask;
	end

	always_comb begin
		unique case (ctl.cmd)
			bcbs_pkg::CMD_CLEAR:  new_word = '0;
			bcbs_pkg::CMD_FILL:   new_word = ones;
			bcbs_pkg::CMD_ADD:    new_word = word | range_mask;
			bcbs_pkg::CMD_REMOVE: new_word = word & ~range_mask;
			bcbs_pkg::CMD_OR:     new_word = sel_hit ? (word | ctl.word_value) : word;
			bcbs_pkg::CMD_ANDNOT: new_word = sel_hit ? (word & ~ctl.word_value) : word;
			default:              new_word = word;
		endcase
	end

	// The start of a run is the lowest member at or after the start position;
	// its end is found from the lowest non-member above the run's first byte.
	always_comb begin
		unique case (ctl.mode)
			bcbs_pkg::UM_SEEK_SET: begin
				seek_mask = (ctl.word_sel == ctl.first[7:6]) ? (ones << ctl.first[5:0]) : ones;
				seek_word = word & seek_mask;
			end
			bcbs_pkg::UM_SEEK_CLEAR: begin
				seek_mask = (ctl.word_sel == ctl.lower[7:6]) ? (ones << ctl.lower[5:0]) : ones;
				seek_word = ~word & seek_mask;
			end
			default: begin
				seek_mask = ones;
				seek_word = '0;
			end
		endcase
	end

	assign lsb = bcbs_pkg::lsb64(seek_word);

	assign res.new_word = new_word;
	assign res.pop      = bcbs_pkg::pop64(new_word);
	assign res.hit      = lsb[6];
	assign res.hit_idx  = lsb[5:0];

endmodule

`default_nettype wire

// ===== sv/byte_class_bitmap_set.sv =====
`default_nettype none

// A command's result strobes on done once all four words have been updated;
// a find first runs the search, which visits each word at most twice.
// A new command is taken only when idle or in the done cycle. The shared word unit
// does one 64-bit word per cycle: update and recount, then the run search.
// Reset clears the set and the count to empty and leaves the block idle.
// The done strobe is high for one cycle only; the receiver cannot stall it.
module byte_class_bitmap_set (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  first_char,
	input  wire logic [7:0]  last_char,
	input  wire logic [1:0]  word_index,
	input  wire logic [63:0] word_value,
	output logic             done,
	output logic [8:0]       member_count,
	output logic             char_present,
	output logic             run_found,
	output logic [7:0]       run_lower,
	output logic [7:0]       run_upper
);

	bcbs_pkg::state_t    state_q, state_d;
	logic [63:0]         words_q [bcbs_pkg::NUM_WORDS];
	logic [8:0]          total_q;
	logic [8:0]          cnt_q;
	logic [1:0]          w_q;
	bcbs_pkg::cmd_t      cmd_q;
	logic [7:0]          first_q;
	logic [7:0]          lo_q;
	logic [7:0]          hi_q;
	logic [1:0]          widx_q;
	logic [63:0]         wval_q;
	logic                present_q;
	logic                found_q;
	logic [7:0]          lower_q;
	logic [7:0]          upper_q;

	logic                accept;
	logic                last_word;
	logic [8:0]          cnt_next;
	bcbs_pkg::unit_ctl_t ctl;
	bcbs_pkg::unit_res_t res;

	assign accept    = start && !busy;
	assign last_word = (w_q == 2'd3);
	assign cnt_next  = cnt_q + {2'd0, res.pop};

	always_comb begin
		unique case (state_q)
			bcbs_pkg::ST_SEEK_SET:   ctl.mode = bcbs_pkg::UM_SEEK_SET;
			bcbs_pkg::ST_SEEK_CLEAR: ctl.mode = bcbs_pkg::UM_SEEK_CLEAR;
			default:                 ctl.mode = bcbs_pkg::UM_UPDATE;
		endcase
		ctl.cmd        = cmd_q;
		ctl.word_sel   = w_q;
		ctl.first      = first_q;
		ctl.range_lo   = lo_q;
		ctl.range_hi   = hi_q;
		ctl.word_index = widx_q;
		ctl.word_value = wval_q;
		ctl.lower      = lower_q;
	end

	bcbs_word_unit u_unit (
		.word (words_q[w_q]),
		.ctl  (ctl),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			bcbs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = bcbs_pkg::ST_UPDATE;
				end
			end
			bcbs_pkg::ST_UPDATE: begin
				if (last_word) begin
					state_d = (cmd_q == bcbs_pkg::CMD_FIND) ? bcbs_pkg::ST_SEEK_SET
					                                        : bcbs_pkg::ST_DONE;
				end
			end
			bcbs_pkg::ST_SEEK_SET: begin
				if (res.hit) begin
					state_d = bcbs_pkg::ST_SEEK_CLEAR;
				end else if (last_word) begin
					state_d = bcbs_pkg::ST_DONE;
				end
			end
			bcbs_pkg::ST_SEEK_CLEAR: begin
				if (res.hit || last_word) begin
					state_d = bcbs_pkg::ST_DONE;
				end
			end
			bcbs_pkg::ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
				state_d = start ? bcbs_pkg::ST_UPDATE : bcbs_pkg::ST_IDLE;
			end
			default: begin
				state_d = bcbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcbs_pkg::NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
			total_q <= '0;
		end else if (state_q == bcbs_pkg::ST_UPDATE) begin
			words_q[w_q] <= res.new_word;
			if (last_word) begin
				total_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= bcbs_pkg::cmd_t'(command);
			first_q <= first_char;
			lo_q    <= (first_char > last_char) ? last_char : first_char;
			hi_q    <= (first_char > last_char) ? first_char : last_char;
			widx_q  <= word_index;
			wval_q  <= word_value;
			w_q     <= 2'd0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			lower_q <= '0;
			upper_q <= '0;
		end else begin
			unique case (state_q)
				bcbs_pkg::ST_UPDATE: begin
					cnt_q <= cnt_next;
					if (w_q == first_q[7:6]) begin
						present_q <= res.new_word[first_q[5:0]];
					end
					// The search starts in the word that holds the start position.
					w_q <= last_word ? first_q[7:6] : w_q + 2'd1;
				end
				bcbs_pkg::ST_SEEK_SET: begin
					if (res.hit) begin
						found_q <= 1'b1;
						lower_q <= {w_q, res.hit_idx};
					end else if (!last_word) begin
						w_q <= w_q + 2'd1;
					end
				end
				bcbs_pkg::ST_SEEK_CLEAR: begin
					if (res.hit) begin
						upper_q <= {w_q, res.hit_idx} - 8'd1;
					end else if (last_word) begin
						upper_q <= 8'hff;
					end else begin
						w_q <= w_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign member_count = total_q;
	assign char_present = present_q;
	assign run_found    = found_q;
	assign run_lower    = lower_q;
	assign run_upper    = upper_q;

endmodule

`default_nettype wire

// ===== sv/bcbs_checker.sv =====
`default_nettype none

module bcbs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [8:0]  member_count,
	input wire logic        run_found,
	input wire logic [7:0]  run_lower,
	input wire logic [7:0]  run_upper
);

	// An accepted transaction keeps the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not make the block busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && !run_found |-> run_lower == 8'd0 && run_upper == 8'd0)
		else $error("run bounds set without a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && run_found |-> run_lower <= run_upper)
		else $error("run ends before it starts");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> member_count <= 9'd256)
		else $error("member count above set size");

endmodule

bind byte_class_bitmap_set bcbs_checker u_bcbs_checker (.*);

`default_nettype wire

// ===== dv/tb_byte_class_bitmap_set.sv =====
`timescale 1ns / 1ps

module tb_byte_class_bitmap_set;

	localparam logic [2:0] CMD_RESERVED = 3'd7;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 450;

	typedef struct packed {
		logic [8:0] count;
		logic       present;
		logic       found;
		logic [7:0] lower;
		logic [7:0] upper;
	} set_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [7:0]  first_char;
	logic [7:0]  last_char;
	logic [1:0]  word_index;
	logic [63:0] word_value;
	logic        done;
	logic [8:0]  member_count;
	logic        char_present;
	logic        run_found;
	logic [7:0]  run_lower;
	logic [7:0]  run_upper;

	logic [63:0] set_words [4];
	set_result_t expected_results [$];
	bit          no_gaps;
	int          fail_count;
	int          commands_sent;
	int          results_checked;
	int          finds_sent;
	int          runs_located;
	int          idle_cycles;

	byte_class_bitmap_set u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.first_char   (first_char),
		.last_char    (last_char),
		.word_index   (word_index),
		.word_value   (word_value),
		.done         (done),
		.member_count (member_count),
		.char_present (char_present),
		.run_found    (run_found),
		.run_lower    (run_lower),
		.run_upper    (run_upper)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_member(input int b);
		return set_words[b / 64][b % 64];
	endfunction

	// Applies one command to the local copy of the set and queues the result it must give.
	task automatic predict_command(input logic [2:0] cmd, input logic [7:0] first,
			input logic [7:0] last, input logic [1:0] widx, input logic [63:0] wval);
		set_result_t res;
		int lo;
		int hi;
		int pos;
		int total;
		res = '0;
		case (cmd)
			bcbs_pkg::CMD_CLEAR: begin
				for (int w = 0; w < 4; w++) set_words[w] = '0;
			end
			bcbs_pkg::CMD_FILL: begin
				for (int w = 0; w < 4; w++) set_words[w] = '1;
			end
			bcbs_pkg::CMD_ADD, bcbs_pkg::CMD_REMOVE: begin
				lo = (first < last) ? first : last;
				hi = (first < last) ? last : first;
				for (int b = lo; b <= hi; b++)
					set_words[b / 64][b % 64] = (cmd == bcbs_pkg::CMD_ADD);
			end
			bcbs_pkg::CMD_OR: set_words[widx] = set_words[widx] | wval;
			bcbs_pkg::CMD_ANDNOT: set_words[widx] = set_words[widx] & ~wval;
			bcbs_pkg::CMD_FIND: begin
				finds_sent++;
				pos = first;
				while (pos < 256 && !is_member(pos)) pos++;
				if (pos < 256) begin
					runs_located++;
					res.found = 1'b1;
					res.lower = pos[7:0];
					while (pos < 256 && is_member(pos)) pos++;
					res.upper = 8'(pos - 1);
				end
			end
			default: ;
		endcase
		total = 0;
		for (int w = 0; w < 4; w++) total += $countones(set_words[w]);
		res.count = total[8:0];
		res.present = is_member(first);
		expected_results.push_back(res);
	endtask

	task automatic send_command(input logic [2:0] cmd, input logic [7:0] first,
			input logic [7:0] last, input logic [1:0] widx, input logic [63:0] wval);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		first_char <= first;
		last_char <= last;
		word_index <= widx;
		word_value <= wval;
		do @(posedge clk); while (busy);
		predict_command(cmd, first, last, widx, wval);
		commands_sent++;
	endtask

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		set_result_t exp;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no command outstanding");
				fail_count++;
			end else begin
				exp = expected_results.pop_front();
				check_field("member_count", exp.count, member_count);
				check_field("char_present", exp.present, char_present);
				check_field("run_found", exp.found, run_found);
				check_field("run_lower", exp.lower, run_lower);
				check_field("run_upper", exp.upper, run_upper);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic test_empty_after_reset();
		send_command(bcbs_pkg::CMD_FIND, 8'd0, 8'd255, 2'd0, '0);
		send_command(CMD_RESERVED, 8'd255, 8'd0, 2'd3, '1);
	endtask

	task automatic test_fill_and_clear();
		send_command(bcbs_pkg::CMD_FILL, 8'd128, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd0, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd255, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_CLEAR, 8'd0, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd0, 8'd0, 2'd0, '0);
	endtask

	task automatic test_ranges();
		send_command(bcbs_pkg::CMD_ADD, 8'd10, 8'd20, 2'd0, '0);
		// Reversed ends must be swapped, and a one-byte range is legal.
		send_command(bcbs_pkg::CMD_ADD, 8'd70, 8'd60, 2'd0, '0);
		send_command(bcbs_pkg::CMD_ADD, 8'd255, 8'd255, 2'd0, '0);
		send_command(bcbs_pkg::CMD_REMOVE, 8'd15, 8'd12, 2'd0, '0);
		send_command(bcbs_pkg::CMD_ADD, 8'd0, 8'd0, 2'd0, '0);
	endtask

	task automatic test_find_runs();
		send_command(bcbs_pkg::CMD_FIND, 8'd1, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd21, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd71, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_REMOVE, 8'd255, 8'd0, 2'd0, '0);
		send_command(bcbs_pkg::CMD_FIND, 8'd0, 8'd0, 2'd0, '0);
	endtask

	task automatic test_word_ops();
		send_command(bcbs_pkg::CMD_OR, 8'd64, 8'd0, 2'd1, '1);
		send_command(bcbs_pkg::CMD_OR, 8'd255, 8'd0, 2'd3, 64'h8000_0000_0000_0001);
		send_command(bcbs_pkg::CMD_ANDNOT, 8'd100, 8'd0, 2'd1, 64'h0000_00F0_0000_0000);
		send_command(bcbs_pkg::CMD_OR, 8'd130, 8'd0, 2'd2, 64'hAAAA_5555_AAAA_5555);
		send_command(bcbs_pkg::CMD_ANDNOT, 8'd0, 8'd0, 2'd0, '1);
		send_command(bcbs_pkg::CMD_FIND, 8'd64, 8'd0, 2'd0, '0);
		send_command(CMD_RESERVED, 8'd64, 8'd33, 2'd2, 64'h1234);
	endtask

	task automatic test_random_mix();
		int pick;
		int lo;
		int hi;
		logic [63:0] wval;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			lo = $urandom_range(0, 255);
			hi = lo + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15));
			if (hi > 255) hi = 255;
			case ($urandom_range(0, 3))
				0: wval = {$urandom, $urandom};
				1: wval = {$urandom, $urandom} & {$urandom, $urandom};
				2: wval = ({64{1'b1}} << $urandom_range(0, 63)) & ({64{1'b1}} >> $urandom_range(0, 63));
				default: wval = '1;
			endcase
			if ($urandom_range(0, 1)) begin
				{lo, hi} = {hi, lo};
			end
			if (pick < 3)
				send_command(bcbs_pkg::CMD_CLEAR, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 6)
				send_command(bcbs_pkg::CMD_FILL, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 31)
				send_command(bcbs_pkg::CMD_ADD, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 49)
				send_command(bcbs_pkg::CMD_REMOVE, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 61)
				send_command(bcbs_pkg::CMD_OR, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 73)
				send_command(bcbs_pkg::CMD_ANDNOT, 8'(lo), 8'(hi), 2'($urandom), wval);
			else if (pick < 98)
				send_command(bcbs_pkg::CMD_FIND, 8'(lo), 8'(hi), 2'($urandom), wval);
			else
				send_command(CMD_RESERVED, 8'(lo), 8'(hi), 2'($urandom), wval);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = bcbs_pkg::CMD_CLEAR;
		first_char = '0;
		last_char = '0;
		word_index = '0;
		word_value = '0;
		no_gaps = 1'b0;
		fail_count = 0;
		commands_sent = 0;
		results_checked = 0;
		finds_sent = 0;
		runs_located = 0;
		for (int w = 0; w < 4; w++) set_words[w] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_after_reset();
		test_fill_and_clear();
		test_ranges();
		test_find_runs();
		test_word_ops();
		test_random_mix();

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Summary: %0d commands, %0d results checked; %0d finds, %0d located a run.",
			commands_sent, results_checked, finds_sent, runs_located);
		$display("Covered clear, fill, ranges either way round, word union and difference, the unused code.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
